// ----- src/chol_pkg.sv -----
// ----------------------------------------------------------------------------
// chol_pkg: shared types and constants of the Cholesky factorization block
// Controller state, command and status bundles, arithmetic widths.
// ----------------------------------------------------------------------------
`default_nettype none

package chol_pkg;

    localparam int MAX_DIM_DEFAULT = 8;
    localparam int DATA_W          = 32;
    localparam int ACC_W           = 50;   // sum of up to seven 48-bit products
    localparam int DIV_STEPS       = 48;   // quotient bits of (diff << 16) / d
    localparam int SQRT_STEPS      = 24;   // root bits of a 48-bit radicand
    localparam int ITER_W          = 6;
    localparam logic [3:0] SIZE_RESET = 4'd8;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_FETCH,
        ST_DIFF,
        ST_CALC,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic mem_we;
        logic wr_result;
        logic rd_en;
        logic mac_issue;
        logic acc_clr;
        logic start_div;
        logic start_sqrt;
        logic out_zero;
        logic err_clr;
    } cmd_t;

    typedef struct packed {
        logic unit_busy;
    } status_t;

endpackage

`default_nettype wire

// ----- src/chol_dp.sv -----
// ----------------------------------------------------------------------------
// chol_dp: datapath of the Cholesky factorization block
// Matrix store, multiply-accumulate pipeline, radix-2 divider and bitwise
// square root, pivot error flag.
// ----------------------------------------------------------------------------
`default_nettype none

module chol_dp #(
    parameter int MAX_DIM = chol_pkg::MAX_DIM_DEFAULT,
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int ADDR_W = 2 * IDX_W
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  chol_pkg::cmd_t              cmd,
    output chol_pkg::status_t           status,
    input  wire [ADDR_W-1:0]            addr_a,
    input  wire [ADDR_W-1:0]            addr_b,
    input  wire signed [31:0]           element_value,
    output logic signed [31:0]          factor_value,
    output logic                        pivot_error
);
    import chol_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_a_reg;
    logic signed [31:0] rd_b_reg;
    logic signed [31:0] wdata;
    logic signed [31:0] result;

    logic               mac_v_reg;
    logic               prod_v_reg;
    logic signed [63:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    logic signed [ACC_W:0] diff_wide;
    logic signed [31:0]    diff_sat;
    logic [31:0]           diff_mag;
    logic                  diff_nonpos;

    logic [DIV_STEPS-1:0] quo_reg;
    logic [31:0]          rem_reg;
    logic [30:0]          dvs_reg;
    logic                 neg_reg;
    logic                 dpos_reg;
    logic [31:0]          div_shift;
    logic                 div_ge;
    logic signed [31:0]   div_res;

    logic [47:0] x_reg;
    logic [47:0] res_reg;
    logic [47:0] bit_reg;
    logic        pos_reg;
    logic [47:0] sq_trial;
    logic        sq_ge;

    logic              mode_sqrt_reg;
    logic              busy_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              err_reg;

    // store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[addr_a] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    assign wdata = cmd.wr_result ? result : element_value;

    // multiply-accumulate: read -> product -> accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            mac_v_reg  <= cmd.mac_issue;
            prod_v_reg <= mac_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_v_reg)
        begin
            prod_reg <= rd_a_reg * rd_b_reg;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Q32.32 to Q16.16 by arithmetic shift: rounds toward minus infinity
    assign acc_next = acc_reg + {{(ACC_W-48){prod_reg[63]}}, prod_reg[63:16]};

    // element minus dot product, saturated to 32 bits
    always_comb
    begin
        diff_wide = {{(ACC_W-31){rd_a_reg[31]}}, rd_a_reg} - {acc_reg[ACC_W-1], acc_reg};
        if (diff_wide[ACC_W:31] == '0 || diff_wide[ACC_W:31] == '1)
        begin
            diff_sat = diff_wide[31:0];
        end
        else if (diff_wide[ACC_W])
        begin
            diff_sat = 32'sh8000_0000;
        end
        else
        begin
            diff_sat = 32'sh7FFF_FFFF;
        end
        diff_mag    = diff_sat[31] ? (~diff_sat + 32'd1) : diff_sat;
        diff_nonpos = diff_sat[31] || (diff_sat == 32'sd0);
    end

    // restoring divider step
    assign div_shift = {rem_reg[30:0], quo_reg[DIV_STEPS-1]};
    assign div_ge    = div_shift >= {1'b0, dvs_reg};

    // bitwise square root step
    assign sq_trial = res_reg + bit_reg;
    assign sq_ge    = x_reg >= sq_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start_div)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(DIV_STEPS - 1);
            end
            else if (cmd.start_sqrt)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(SQRT_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (iter_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                iter_reg <= iter_reg - ITER_W'(1);
            end
            if (cmd.err_clr)
            begin
                err_reg <= 1'b0;
            end
            else if (cmd.start_sqrt && diff_nonpos)
            begin
                err_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            mode_sqrt_reg <= 1'b0;
            quo_reg       <= {diff_mag, 16'd0};
            rem_reg       <= '0;
            dvs_reg       <= rd_b_reg[30:0];
            neg_reg       <= diff_sat[31];
            dpos_reg      <= !rd_b_reg[31] && (rd_b_reg != 32'sd0);
        end
        else if (cmd.start_sqrt)
        begin
            mode_sqrt_reg <= 1'b1;
            x_reg         <= {diff_sat, 16'd0};
            res_reg       <= '0;
            bit_reg       <= {2'b01, 46'd0};
            pos_reg       <= !diff_nonpos;
        end
        else if (busy_reg)
        begin
            if (mode_sqrt_reg)
            begin
                if (sq_ge)
                begin
                    x_reg   <= x_reg - sq_trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                rem_reg <= div_ge ? (div_shift - {1'b0, dvs_reg}) : div_shift;
                quo_reg <= {quo_reg[DIV_STEPS-2:0], div_ge};
            end
        end
    end

    // quotient sign and saturation
    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > DIV_STEPS'(64'h8000_0000))
            begin
                div_res = 32'sh8000_0000;
            end
            else
            begin
                div_res = -quo_reg[31:0];
            end
        end
        else if (quo_reg > DIV_STEPS'(64'h7FFF_FFFF))
        begin
            div_res = 32'sh7FFF_FFFF;
        end
        else
        begin
            div_res = quo_reg[31:0];
        end
    end

    always_comb
    begin
        if (mode_sqrt_reg)
        begin
            result = pos_reg ? res_reg[31:0] : 32'sd0;
        end
        else
        begin
            result = dpos_reg ? div_res : 32'sd0;
        end
    end

    assign status.unit_busy = busy_reg;
    assign factor_value     = cmd.out_zero ? 32'sd0 : rd_a_reg;
    assign pivot_error      = err_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_div || cmd.start_sqrt) |-> !busy_reg)
        else $error("unit started while busy");

    a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_div || cmd.start_sqrt) |-> (!mac_v_reg && !prod_v_reg))
        else $error("unit started before accumulator drained");

    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_we && cmd.wr_result) |-> !busy_reg)
        else $error("result written while unit busy");

endmodule

`default_nettype wire

// ----- src/chol_ctrl.sv -----
// ----------------------------------------------------------------------------
// chol_ctrl: sequencer of the Cholesky factorization block
// Load, row-by-row factorization and row-major emission, plus size register.
// ----------------------------------------------------------------------------
`default_nettype none

module chol_ctrl #(
    parameter int MAX_DIM = chol_pkg::MAX_DIM_DEFAULT,
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int ADDR_W = 2 * IDX_W
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [3:0]             cfg_data,
    input  wire                   in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic                  last_element,
    output chol_pkg::cmd_t        cmd,
    input  chol_pkg::status_t     status,
    output logic [ADDR_W-1:0]     addr_a,
    output logic [ADDR_W-1:0]     addr_b
);
    import chol_pkg::*;

    localparam logic [3:0] MAX_M1 = 4'(MAX_DIM - 1);

    state_t state_reg, state_next;
    logic [3:0]       size_reg;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [3:0]       dm1_full;
    logic [IDX_W-1:0] dm1;
    logic             cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        if (size_reg == 4'd0)
        begin
            dm1_full = 4'd0;
        end
        else if (size_reg > 4'(MAX_DIM))
        begin
            dm1_full = MAX_M1;
        end
        else
        begin
            dm1_full = size_reg - 4'd1;
        end
        dm1 = dm1_full[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            size_reg  <= SIZE_RESET;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            state_reg <= ST_LOAD;
            size_reg  <= cfg_data;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    // next state and loop counters
    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (c_reg == dm1)
                    begin
                        c_next = '0;
                        if (r_reg == dm1)
                        begin
                            r_next     = '0;
                            k_next     = '0;
                            state_next = ST_MAC;
                        end
                        else
                        begin
                            r_next = r_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        c_next = c_reg + IDX_W'(1);
                    end
                end
            end
            ST_MAC:
            begin
                if (k_reg < c_reg)
                begin
                    k_next = k_reg + IDX_W'(1);
                end
                else
                begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_CALC;
            ST_CALC:
            begin
                if (!status.unit_busy)
                begin
                    k_next = '0;
                    if (c_reg == r_reg)
                    begin
                        c_next = '0;
                        if (r_reg == dm1)
                        begin
                            r_next     = '0;
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            r_next     = r_reg + IDX_W'(1);
                            state_next = ST_MAC;
                        end
                    end
                    else
                    begin
                        c_next     = c_reg + IDX_W'(1);
                        state_next = ST_MAC;
                    end
                end
            end
            ST_OUT_RD: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_OUT_RD;
                    if (c_reg == dm1)
                    begin
                        c_next = '0;
                        if (r_reg == dm1)
                        begin
                            r_next     = '0;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            r_next = r_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        c_next = c_reg + IDX_W'(1);
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // commands and handshake outputs
    always_comb
    begin
        cmd          = '0;
        addr_a       = {r_reg, c_reg};
        addr_b       = {c_reg, c_reg};
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        last_element = (r_reg == dm1) && (c_reg == dm1);
        cmd.err_clr  = cfg_wr;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready    = 1'b1;
                cmd.mem_we  = in_valid;
                cmd.acc_clr = 1'b1;
            end
            ST_MAC:
            begin
                addr_a        = {r_reg, k_reg};
                addr_b        = {c_reg, k_reg};
                cmd.rd_en     = k_reg < c_reg;
                cmd.mac_issue = k_reg < c_reg;
            end
            ST_DRAIN1, ST_DRAIN2: ;
            ST_FETCH: cmd.rd_en = 1'b1;
            ST_DIFF:
            begin
                cmd.start_div  = c_reg != r_reg;
                cmd.start_sqrt = c_reg == r_reg;
            end
            ST_CALC:
            begin
                cmd.mem_we    = !status.unit_busy;
                cmd.wr_result = 1'b1;
                cmd.acc_clr   = !status.unit_busy;
            end
            ST_OUT_RD: cmd.rd_en = 1'b1;
            ST_OUT:
            begin
                out_valid    = 1'b1;
                cmd.out_zero = c_reg > r_reg;
                cmd.err_clr  = cfg_wr || (out_ready && last_element);
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/cholesky_factorization.sv -----
// ----------------------------------------------------------------------------
// cholesky_factorization: in-place Cholesky factor of an n x n Q16.16 matrix
// Loads n*n elements row-major, factors into the lower triangle, emits n*n.
// ----------------------------------------------------------------------------
// Load: one element per cycle while in_ready is high; factoring streams
//   each entry's dot product through the MAC, then runs the radix-2 divider
//   (off-diagonals) or the bitwise square root (diagonals).
// Emission: a registered store read precedes each element; out_ready stalls it.
// Reset: rst_n asynchronous active low; size returns to 8, counters and the
//   pivot error clear; the matrix store is not cleared.
`default_nettype none

module cholesky_factorization #(
    parameter int MAX_DIM = chol_pkg::MAX_DIM_DEFAULT
) (
    input  wire                clk,
    input  wire                rst_n,
    // configuration: matrix size, one transaction per write
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire [3:0]          cfg_data,
    // element input
    input  wire                in_valid,
    output logic               in_ready,
    input  wire signed [31:0]  element_value,
    // factor output
    output logic               out_valid,
    input  wire                out_ready,
    output logic signed [31:0] factor_value,
    output logic               last_element,
    output logic               pivot_error
);
    import chol_pkg::*;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * IDX_W;

    cmd_t              cmd;
    status_t           status;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;

    // The sequencer walks row i, column j <= i; for each entry it streams the
    // dot product through the MAC, then runs the divider (off-diagonal) or
    // the square root (diagonal) and writes the result back in place.
    // Upper-triangle outputs are forced to zero during emission.
    chol_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .last_element (last_element),
        .cmd          (cmd),
        .status       (status),
        .addr_a       (addr_a),
        .addr_b       (addr_b)
    );

    chol_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .addr_a        (addr_a),
        .addr_b        (addr_b),
        .element_value (element_value),
        .factor_value  (factor_value),
        .pivot_error   (pivot_error)
    );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the Cholesky factorization block
// Streams Q16.16 matrices of several sizes, predicts the lower factor in a
// local fixed-point model and compares every output transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int DIM = 8;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [3:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] element_value;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] factor_value;
    logic               last_element;
    logic               pivot_error;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               err;
    } factor_t;

    cholesky_factorization dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .factor_value  (factor_value),
        .last_element  (last_element),
        .pivot_error   (pivot_error)
    );

    // clock: 10 time units
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor state: private copy of the matrix store and size register
    // ------------------------------------------------------------------------
    logic signed [31:0] mat_model [64];
    int                 loaded_count;
    logic [3:0]         size_reg;
    factor_t            factor_expected [$];

    // pending element transactions for the driver
    logic signed [31:0] element_queue [$];

    int  mismatch_count;
    int  result_count;
    int  matrix_count;
    int  error_matrix_count;
    bit  hold_off;          // long receiver hold-off, set by the stimulus process

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, floor of exact Q32.32
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;    // arithmetic shift floors toward minus infinity
    endfunction

    function automatic longint root_floor(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x)
            b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic int dim_of(logic [3:0] s);
        if (s == 4'd0)
            return 1;
        if (s > DIM)
            return DIM;
        return int'(s);
    endfunction

    // factor the loaded matrix and queue all n*n expected transactions
    task automatic factor_matrix(int n);
        longint acc;
        longint diff;
        longint d;
        longint q;
        bit     err;
        err = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < i; j++)
            begin
                acc = 0;
                for (int k = 0; k < j; k++)
                    acc += qmul(longint'(mat_model[i*DIM+k]),
                                longint'(mat_model[j*DIM+k]));
                diff = sat32(longint'(mat_model[i*DIM+j]) - acc);
                d    = longint'(mat_model[j*DIM+j]);
                q    = 0;
                if (d > 0)
                    q = sat32((diff * 65536) / d);
                mat_model[i*DIM+j] = q[31:0];
            end
            acc = 0;
            for (int k = 0; k < i; k++)
                acc += qmul(longint'(mat_model[i*DIM+k]),
                            longint'(mat_model[i*DIM+k]));
            diff = sat32(longint'(mat_model[i*DIM+i]) - acc);
            if (diff <= 0)
            begin
                err = 1'b1;
                mat_model[i*DIM+i] = '0;
            end
            else
                mat_model[i*DIM+i] = 32'(root_floor(diff <<< 16));
            for (int j = i + 1; j < n; j++)
                mat_model[i*DIM+j] = '0;
        end
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                factor_expected.push_back('{mat_model[r*DIM+c],
                                            (r*n + c + 1 == n*n), err});
        matrix_count++;
        if (err)
            error_matrix_count++;
    endtask

    task automatic load_element(logic signed [31:0] v);
        int n;
        n = dim_of(size_reg);
        if (loaded_count >= n*n)
            loaded_count = 0;
        mat_model[(loaded_count / n)*DIM + (loaded_count % n)] = v;
        loaded_count++;
        if (loaded_count == n*n)
        begin
            factor_matrix(n);
            loaded_count = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of random length with random gaps between them.
    // Each accepted transaction goes through the predictor at that edge.
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            element_value <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                load_element(element_value);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (element_queue.size() > 0)
                begin
                    in_valid      <= 1'b1;
                    element_value <= element_queue.pop_front();
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(40, 0);
                        gap_left   <= ($urandom_range(3, 0) == 0) ? 0
                                                                  : $urandom_range(6, 0);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and receiver: stalls on a pattern that changes phase slowly,
    // plus the long hold-off requested by the stimulus process.
    // ------------------------------------------------------------------------
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                factor_t want;
                result_count++;
                if (factor_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected output transaction: value %h", factor_value);
                end
                else
                begin
                    want = factor_expected.pop_front();
                    if (factor_value !== want.value || last_element !== want.last ||
                        pivot_error !== want.err)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %h/%0b/%0b got %h/%0b/%0b",
                                     want.value, want.last, want.err,
                                     factor_value, last_element, pivot_error);
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 256;
            if (hold_off)
                out_ready <= 1'b0;
            else if (stall_phase < 96)
                out_ready <= 1'b1;          // no stalls in this stretch
            else
                out_ready <= ($urandom_range(3, 0) != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // well-formed SPD matrix: diagonally dominant symmetric, scaled by mag
    task automatic push_spd(int n, int mag);
        logic signed [31:0] m [64];
        for (int r = 0; r < n; r++)
            for (int c = 0; c <= r; c++)
            begin
                m[r*DIM+c] = $signed($urandom_range(2*mag, 0)) - mag;
                m[c*DIM+r] = m[r*DIM+c];
            end
        for (int r = 0; r < n; r++)
            m[r*DIM+r] = n * mag + $urandom_range(mag, 1);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                element_queue.push_back(m[r*DIM+c]);
    endtask

    task automatic push_noise(int count);
        for (int i = 0; i < count; i++)
            element_queue.push_back($urandom());
    endtask

    task automatic wait_drained();
        while (element_queue.size() > 0 || in_valid || factor_expected.size() > 0)
            @(posedge clk);
    endtask

    // write the size register while idle; the block may still be factoring
    // a matrix that left no result, so allow its full latency first
    task automatic write_size(logic [3:0] s);
        wait_drained();
        repeat (2500) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= s;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        size_reg      = s;
        loaded_count  = 0;
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        hold_off           = 1'b0;
        mismatch_count     = 0;
        result_count       = 0;
        matrix_count       = 0;
        error_matrix_count = 0;
        loaded_count       = 0;
        size_reg           = 4'd8;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: size 1 with field extremes and non-positive pivots
        write_size(4'd1);
        element_queue.push_back(32'sh7fffffff);
        element_queue.push_back(32'sh80000000);
        element_queue.push_back(32'sh00000000);
        element_queue.push_back(32'sh00010000);
        element_queue.push_back(32'sh00000001);
        // size 0 acts as 1
        write_size(4'd0);
        element_queue.push_back(32'sh00040000);
        // size 2: identity, then zero pivot followed by a zero-divisor entry
        write_size(4'd2);
        element_queue.push_back(32'sh00010000);
        element_queue.push_back(32'sh00000000);
        element_queue.push_back(32'sh00000000);
        element_queue.push_back(32'sh00010000);
        element_queue.push_back(32'sh00000000);
        element_queue.push_back(32'sh00030000);
        element_queue.push_back(32'sh00030000);
        element_queue.push_back(32'sh00050000);
        // saturating quotient: tiny diagonal, huge off-diagonal
        element_queue.push_back(32'sh00000001);
        element_queue.push_back(32'sh7fffffff);
        element_queue.push_back(32'sh7fffffff);
        element_queue.push_back(32'sh7fffffff);
        // a partly loaded matrix is discarded by a size write
        element_queue.push_back(32'sh00020000);
        wait_drained();
        write_size(4'd15);              // above range acts as 8
        push_spd(8, 32'h10000);

        // random phases over several sizes, one matrix each, three in phase 4
        for (int phase = 0; phase < 10; phase++)
        begin
            int n;
            write_size((phase == 9) ? 4'd8 : 4'($urandom_range(8, 1)));
            n = dim_of(size_reg);
            if ($urandom_range(5, 0) == 0)
                push_noise(n*n);        // random content, usually pivot errors
            else
                push_spd(n, $urandom_range(32'h40000, 1));
            if (phase == 4)
            begin
                // long receiver hold-off while the sender keeps offering
                push_spd(n, 32'h8000);
                push_spd(n, 32'h8000);
                hold_off = 1'b1;
                repeat (6000) @(posedge clk);
                hold_off = 1'b0;
            end
            if (phase == 6)
                wait_drained();         // sender pauses until all results arrive
        end

        wait_drained();
        repeat (2500) @(posedge clk);
        $display("summary: %0d matrices (%0d with pivot errors), %0d results checked",
                 matrix_count, error_matrix_count, result_count);
        if (mismatch_count == 0 && factor_expected.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // limit on run length
    initial
    begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
